### rtl/suk_pkg.sv
package suk_pkg;

    localparam int CAPACITY = 32;
    localparam int KEY_BITS = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ENTRY_W  = 6;
    localparam int ID_W     = 16;
    localparam int OUT_W    = 16;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_INS  = 2'd1,
        OP_REM  = 2'd2
    } op_t;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // broadcast to every cell
    typedef struct packed {
        op_t                 op;
        logic [KEY_BITS-1:0] key;
    } cmd_t;

    // what a cell shows its neighbours
    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic                valid;
        logic                gt;
    } link_t;

endpackage

### rtl/suk_cell.sv
module suk_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  suk_pkg::cmd_t  cmd,
    input  suk_pkg::link_t left,
    input  suk_pkg::link_t right,
    output suk_pkg::link_t self_link,
    output logic          hit
);
    import suk_pkg::*;

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic                valid_reg;
    logic                valid_next;
    logic                gt;

    assign gt  = valid_reg && (key_reg > cmd.key);
    assign hit = valid_reg && (key_reg == cmd.key);

    assign self_link.key   = key_reg;
    assign self_link.valid = valid_reg;
    assign self_link.gt    = gt;

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        case (cmd.op)
            OP_INS:
            begin
                if (left.gt)
                begin
                    // larger keys move up one place
                    key_next   = left.key;
                    valid_next = 1'b1;
                end
                else if (left.valid && (gt || !valid_reg))
                begin
                    // first slot above the smaller keys takes the new one
                    key_next   = cmd.key;
                    valid_next = 1'b1;
                end
            end
            OP_REM:
            begin
                if (gt || hit)
                begin
                    key_next   = right.key;
                    valid_next = right.valid;
                end
            end
            default:
            begin
                key_next   = key_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

### rtl/suk_chain.sv
module suk_chain (
    input  logic         clk,
    input  logic         rst_n,
    input  suk_pkg::cmd_t cmd,
    output logic         found
);
    import suk_pkg::*;

    link_t                links [CAPACITY];
    link_t                lefts [CAPACITY];
    link_t                rights[CAPACITY];
    logic [CAPACITY-1:0]  hits;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            if (i == 0)
            begin : g_first
                // bottom of the table behaves as a valid key below everything
                assign lefts[i] = '{key: '0, valid: 1'b1, gt: 1'b0};
            end
            else
            begin : g_mid_l
                assign lefts[i] = links[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign rights[i] = '{key: '0, valid: 1'b0, gt: 1'b0};
            end
            else
            begin : g_mid_r
                assign rights[i] = links[i+1];
            end

            suk_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .left      (lefts[i]),
                .right     (rights[i]),
                .self_link (links[i]),
                .hit       (hits[i])
            );
        end
    endgenerate

    assign found = |hits;

endmodule

### rtl/sorted_unique_key_table.sv
// sorted table of unique keys held in a row of compare-and-shift cells
// slave side: one request per beat; s_axis_tuser is the request type
// (insert or remove), s_axis_tdata carries the identifier
// master side: one result beat per request with status, a changed flag
// and the number of stored keys after the request
// every cell compares its key with the request key in the same cycle, so
// a request is decided and the table shifted on the clock edge that accepts it
// the result is registered and shown the cycle after the request beat
// one request per cycle while results are taken; the single output
// register holds a result until the receiver takes it and the slave
// side stalls only while that register is full and not being read
// an insert into a full table is refused with the full status; a
// duplicate is reported ahead of full
// reset empties the table at once (valid flags cleared, keys left as
// they are) and drops any pending result
module sorted_unique_key_table (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [suk_pkg::ID_W-1:0]  s_axis_tdata,  // [15:0] process_id
    input  logic                      s_axis_tuser,  // [0] req_type
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [suk_pkg::OUT_W-1:0] m_axis_tdata   // [2:0] status_code, [3] done_ok,
                                                     // [9:4] entry_count, rest zero
);
    import suk_pkg::*;

    cmd_t                cmd;
    logic                found;
    logic                accept;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    status_t             status;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [OUT_W-1:0]    m_data_reg;
    logic [OUT_W-1:0]    m_data_next;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        cmd.key    = KEY_BITS'(s_axis_tdata);
        cmd.op     = OP_NONE;
        count_next = count_reg;
        status     = ST_NOT_FOUND;
        if (s_axis_tuser == REQ_INSERT)
        begin
            if (found)
                status = ST_DUPLICATE;
            else if (count_reg == CNT_W'(CAPACITY))
                status = ST_FULL;
            else
            begin
                status = ST_INSERTED;
                if (accept)
                begin
                    cmd.op     = OP_INS;
                    count_next = count_reg + 1'b1;
                end
            end
        end
        else
        begin
            if (found)
            begin
                status = ST_REMOVED;
                if (accept)
                begin
                    cmd.op     = OP_REM;
                    count_next = count_reg - 1'b1;
                end
            end
        end
    end

    suk_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .found (found)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept)
        begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            m_data_next[2:0] = status;
            m_data_next[3]   = (status == ST_INSERTED) || (status == ST_REMOVED);
            m_data_next[4 +: ENTRY_W] = ENTRY_W'(count_next);
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

### bench/suk_table_checker.sv
module suk_table_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic [suk_pkg::ID_W-1:0]  s_axis_tdata,   // [15:0] process_id
    input  logic                      s_axis_tuser,   // [0] req_type
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [suk_pkg::OUT_W-1:0] m_axis_tdata,   // [2:0] status_code, [3] done_ok,
                                                      // [9:4] entry_count, rest zero
    output int                        errors,
    output int                        pending,
    output int                        results_seen,
    output int                        peak_fill,
    output bit [4:0]                  status_hits
);
    import suk_pkg::*;

    typedef struct packed {
        status_t             status;
        logic                changed;
        logic [ENTRY_W-1:0]  count;
    } outcome_t;

    // identifiers currently held, kept in ascending order
    logic [KEY_BITS-1:0] held_ids[$];
    outcome_t            awaited_results[$];

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (errors < 20)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    function automatic outcome_t apply_request(input logic req,
                                               input logic [KEY_BITS-1:0] key);
        outcome_t res;
        int       pos;
        int       fill;
        bit       hit;
        pos = 0;
        while (pos < held_ids.size() && held_ids[pos] < key)
            pos++;
        hit = (pos < held_ids.size()) && (held_ids[pos] == key);
        if (req == REQ_INSERT)
        begin
            // a duplicate is reported ahead of a full table
            if (hit)
                res.status = ST_DUPLICATE;
            else if (held_ids.size() >= CAPACITY)
                res.status = ST_FULL;
            else
            begin
                held_ids.insert(pos, key);
                res.status = ST_INSERTED;
            end
        end
        else if (hit)
        begin
            held_ids.delete(pos);
            res.status = ST_REMOVED;
        end
        else
            res.status = ST_NOT_FOUND;
        res.changed = (res.status == ST_INSERTED) || (res.status == ST_REMOVED);
        fill = held_ids.size();
        res.count = fill[ENTRY_W-1:0];
        return res;
    endfunction

    always @(posedge clk)
    begin : watch
        outcome_t want;
        if (rst_n)
        begin
            // a result beat always belongs to an earlier request, so retire it first
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (awaited_results.size() == 0)
                    report_mismatch("unexpected result beat", m_axis_tdata, 0);
                else
                begin
                    want = awaited_results.pop_front();
                    status_hits[int'(want.status)] = 1'b1;
                    if (m_axis_tdata[2:0] !== want.status)
                        report_mismatch("status_code", m_axis_tdata[2:0], want.status);
                    if (m_axis_tdata[3] !== want.changed)
                        report_mismatch("done_ok", m_axis_tdata[3], want.changed);
                    if (m_axis_tdata[9:4] !== want.count)
                        report_mismatch("entry_count", m_axis_tdata[9:4], want.count);
                    if (m_axis_tdata[OUT_W-1:10] !== '0)
                        report_mismatch("tdata padding", m_axis_tdata[OUT_W-1:10], 0);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                awaited_results.push_back(apply_request(s_axis_tuser, s_axis_tdata));
                if (held_ids.size() > peak_fill)
                    peak_fill = held_ids.size();
            end
            pending = awaited_results.size();
        end
    end

    final
    begin
        if (awaited_results.size() != 0)
            $display("%0d results never arrived", awaited_results.size());
    end

endmodule

### bench/sorted_unique_key_table_tb.sv
module sorted_unique_key_table_tb;

    import suk_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int POOL_SPAN   = 48;

    logic             clk;
    logic             rst_n         = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [ID_W-1:0]  s_axis_tdata  = '0;   // [15:0] process_id
    logic             s_axis_tuser  = REQ_INSERT;   // [0] req_type
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;   // [2:0] status_code, [3] done_ok, [9:4] entry_count

    int       idle_pct     = 0;
    int       stall_pct    = 0;
    bit       hold_request = 1'b0;
    int       held;
    int       cycle_count  = 0;
    int       inserts_sent = 0;
    int       removes_sent = 0;
    int       errors;
    int       pending;
    int       results_seen;
    int       peak_fill;
    bit [4:0] status_hits;

    sorted_unique_key_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    suk_table_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (errors),
        .pending       (pending),
        .results_seen  (results_seen),
        .peak_fill     (peak_fill),
        .status_hits   (status_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // result side: random stalls, or one long hold-off when asked for
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                hold_request = 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // valid stays high between back-to-back beats and only drops for a gap
    task automatic send_req(input logic req, input logic [ID_W-1:0] id);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= id;
        s_axis_tuser  <= req;
        if (req == REQ_INSERT)
            inserts_sent++;
        else
            removes_sent++;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // fill past capacity from a small pool in scrambled order, then sweep it out
    // again; a few stray pool picks make duplicates and misses, noise the rest
    task automatic fill_and_drain();
        int unsigned base;
        int unsigned off;
        int          k;
        base = $urandom_range(0, 65535 - POOL_SPAN);
        off  = $urandom_range(0, POOL_SPAN - 1);
        for (k = 0; k < POOL_SPAN; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_req($urandom_range(0, 1) ? REQ_REMOVE : REQ_INSERT,
                         ID_W'($urandom_range(0, 65535)));
            else if ($urandom_range(0, 3) == 0)
                send_req(REQ_INSERT, ID_W'(base + $urandom_range(0, POOL_SPAN - 1)));
            else
                send_req(REQ_INSERT, ID_W'(base + (k * 13 + off) % POOL_SPAN));
        end
        off = $urandom_range(0, POOL_SPAN - 1);
        for (k = 0; k < POOL_SPAN; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_req($urandom_range(0, 1) ? REQ_REMOVE : REQ_INSERT,
                         ID_W'($urandom_range(0, 65535)));
            else if ($urandom_range(0, 5) == 0)
                send_req(REQ_REMOVE, ID_W'(base + $urandom_range(0, POOL_SPAN - 1)));
            else
                send_req(REQ_REMOVE, ID_W'(base + (k * 7 + off) % POOL_SPAN));
        end
    endtask

    initial
    begin
        int mode;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // removal from an empty table, key extremes, duplicates, misses
        send_req(REQ_REMOVE, 16'h0005);
        send_req(REQ_INSERT, 16'h0000);
        send_req(REQ_INSERT, 16'hFFFF);
        send_req(REQ_INSERT, 16'h8000);
        send_req(REQ_INSERT, 16'h0000);
        send_req(REQ_INSERT, 16'h7FFF);
        send_req(REQ_INSERT, 16'hFFFF);
        send_req(REQ_REMOVE, 16'h8000);
        send_req(REQ_REMOVE, 16'h8000);
        send_req(REQ_INSERT, 16'h0001);
        send_req(REQ_INSERT, 16'h5555);
        send_req(REQ_INSERT, 16'hAAAA);
        send_req(REQ_REMOVE, 16'h0000);
        send_req(REQ_REMOVE, 16'hFFFF);
        send_req(REQ_REMOVE, 16'h0001);
        send_req(REQ_REMOVE, 16'h7FFF);
        send_req(REQ_REMOVE, 16'h5555);
        send_req(REQ_REMOVE, 16'hAAAA);
        send_req(REQ_REMOVE, 16'h0000);
        wait_for_results();

        for (mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 75; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 75; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            fill_and_drain();
            wait_for_results();
        end

        // back-pressure: output held off while requests keep coming
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request = 1'b1;
        fill_and_drain();
        wait_for_results();

        repeat (5) @(posedge clk);
        $display("sent %0d requests (%0d inserts, %0d removes) over four idling mixes",
                 inserts_sent + removes_sent, inserts_sent, removes_sent);
        $display("and a %0d-cycle output hold; %0d results checked, status codes hit %b,",
                 HOLD_CYCLES, results_seen, status_hits);
        $display("peak fill %0d/%0d", peak_fill, CAPACITY);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
